// ----- hdl/usb_power_remote_switch_decoder_top_defines.svh -----
// Assertion macros used by the checker file of the remote switch decoder.
`ifndef USB_POWER_REMOTE_SWITCH_DECODER_TOP_DEFINES_SVH
`define USB_POWER_REMOTE_SWITCH_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USBPRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define USBPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- hdl/usbprs_pkg.sv -----
// Package: types, codes and reset values of the remote switch decoder.
`default_nettype none

package usbprs_pkg;

    localparam int unsigned FULL_MAX_MS_DEF          = 200;
    localparam int unsigned FULL_WAIT_TIMEOUT_MS_DEF = 2000;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned INDEX_W = 3;

    typedef enum logic [1:0] {
        MODE_ONE_PRESS = 2'd0,
        MODE_TWO_PRESS = 2'd1,
        MODE_PULSE     = 2'd2,
        MODE_OFF       = 2'd3
    } mode_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_DEBOUNCE      = 3'd1,
        REG_MAX_HOLD      = 3'd2,
        REG_FULL_PULSE    = 3'd3,
        REG_SECOND_WAIT   = 3'd4,
        REG_HALF_MIN      = 3'd5,
        REG_HALF_MAX      = 3'd6,
        REG_FULL_MIN      = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_RESET      = 4'd0,
        ST_IDLE       = 4'd1,
        ST_CONNECT    = 4'd2,
        ST_ON         = 4'd3,
        ST_DISCONNECT = 4'd4,
        ST_FULL_ACTIVE = 4'd5,
        ST_SHORT      = 4'd6,
        ST_CANCEL     = 4'd7,
        ST_HALF       = 4'd8,
        ST_FULL       = 4'd9,
        ST_FULL_RESET = 4'd10
    } dec_state_t;

    typedef enum logic [1:0] {
        SH_RELEASE = 2'd0,
        SH_HALF    = 2'd1,
        SH_FULL    = 2'd2
    } shutter_t;

    typedef struct packed {
        mode_t            mode;
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] max_hold_ms;
        logic [CFG_W-1:0] full_pulse_ms;
        logic [CFG_W-1:0] second_press_wait_ms;
        logic [CFG_W-1:0] half_min_ms;
        logic [CFG_W-1:0] half_max_ms;
        logic [CFG_W-1:0] full_min_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:                 MODE_ONE_PRESS,
        debounce_ms:          16'd10,
        max_hold_ms:          16'd5000,
        full_pulse_ms:        16'd100,
        second_press_wait_ms: 16'd1000,
        half_min_ms:          16'd10,
        half_max_ms:          16'd50,
        full_min_ms:          16'd100
    };

    typedef struct packed {
        dec_state_t        state;
        logic [TIME_W-1:0] stamp_ms;
        shutter_t          shutter;
    } dec_ctx_t;

endpackage

`default_nettype wire

// ----- hdl/usb_power_remote_switch_decoder_top.sv -----
// Top level of the remote power switch decoder: input stage, decoder state, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one level sample power_on with its
//   millisecond tick now_ms. A transfer happens at a rising edge with in_valid high
//   and in_stall low.
//   Output channel (out_valid / out_stall) carries remote_state, the shutter state
//   after each sample: 0 release, 1 half press, 2 full press. Every sample yields
//   exactly one result.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes one of
//   the eight registers; cfg_ready is always high. Writing mode puts the decoder back
//   to its reset state with the shutter released. Write only while the block is idle.
// Flow:
//   A transferred sample passes the input register, then the result register, where it can leave.
//   One sample per cycle is sustained while out_stall is low; the elapsed-time compare and the
//   decoder update are combinational between the input and result registers.
// Reset (rst_n, asynchronous, active low): registers take their documented defaults,
//   the decoder enters its reset state, stamp clears, both stages empty.
// Stall: while the result register holds an untaken result under out_stall, the
//   input stage still takes one more sample, then in_stall rises until it drains.
`default_nettype none

module usb_power_remote_switch_decoder_top
    import usbprs_pkg::*;
#(
    parameter int unsigned FULL_MAX_MS          = FULL_MAX_MS_DEF,
    parameter int unsigned FULL_WAIT_TIMEOUT_MS = FULL_WAIT_TIMEOUT_MS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               power_on,
    input  wire logic [TIME_W-1:0]  now_ms,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              remote_state,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    cfg_t     cfg;
    logic     mode_wr;

    // Input stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_on_reg;
    logic [TIME_W-1:0] s1_now_reg;

    // Decoder context
    dec_ctx_t ctx_reg;
    dec_ctx_t ctx_next;
    dec_ctx_t step_ctx;

    // Result register
    logic     out_valid_reg;
    logic     out_valid_next;
    shutter_t out_state_reg;

    logic     out_free;
    logic     s1_fire;
    logic     in_take;

    assign cfg_ready = 1'b1;

    usbprs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .mode_wr   (mode_wr)
    );

    usbprs_step #(
        .FULL_MAX_MS          (FULL_MAX_MS),
        .FULL_WAIT_TIMEOUT_MS (FULL_WAIT_TIMEOUT_MS)
    ) u_step (
        .cfg      (cfg),
        .cur      (ctx_reg),
        .power_on (s1_on_reg),
        .now_ms   (s1_now_reg),
        .nxt      (step_ctx)
    );

    // Advance the input stage whenever the result register is empty or being taken.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !out_free);
    assign out_valid_next = s1_fire || (out_valid_reg && out_stall);

    always_comb
    begin
        ctx_next = ctx_reg;
        if (mode_wr)
        begin
            // Mode change restarts the decoder; keep the stamp.
            ctx_next.state   = ST_RESET;
            ctx_next.shutter = SH_RELEASE;
        end
        else if (s1_fire)
        begin
            ctx_next = step_ctx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            ctx_reg.state    <= ST_RESET;
            ctx_reg.stamp_ms <= '0;
            ctx_reg.shutter  <= SH_RELEASE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            ctx_reg       <= ctx_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_on_reg  <= power_on;
            s1_now_reg <= now_ms;
        end
        if (s1_fire)
        begin
            out_state_reg <= step_ctx.shutter;
        end
    end

    assign out_valid    = out_valid_reg;
    assign remote_state = out_state_reg;

endmodule

`default_nettype wire

// ----- hdl/usbprs_cfg_regs.sv -----
// Configuration register file of the remote switch decoder.
`default_nettype none

module usbprs_cfg_regs
    import usbprs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    output cfg_t                    cfg,
    output logic                    mode_wr
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;

    assign index   = reg_index_t'(cfg_index);
    assign mode_wr = cfg_valid && (index == REG_MODE);
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (index)
                REG_MODE:        cfg_next.mode                 = mode_t'(cfg_data[1:0]);
                REG_DEBOUNCE:    cfg_next.debounce_ms          = cfg_data;
                REG_MAX_HOLD:    cfg_next.max_hold_ms          = cfg_data;
                REG_FULL_PULSE:  cfg_next.full_pulse_ms        = cfg_data;
                REG_SECOND_WAIT: cfg_next.second_press_wait_ms = cfg_data;
                REG_HALF_MIN:    cfg_next.half_min_ms          = cfg_data;
                REG_HALF_MAX:    cfg_next.half_max_ms          = cfg_data;
                REG_FULL_MIN:    cfg_next.full_min_ms          = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/usbprs_step.sv -----
// Next-state logic of the three decoders for one level sample.
`default_nettype none

module usbprs_step
    import usbprs_pkg::*;
#(
    parameter int unsigned FULL_MAX_MS          = FULL_MAX_MS_DEF,
    parameter int unsigned FULL_WAIT_TIMEOUT_MS = FULL_WAIT_TIMEOUT_MS_DEF
)
(
    input  wire cfg_t               cfg,
    input  wire dec_ctx_t           cur,
    input  wire logic               power_on,
    input  wire logic [TIME_W-1:0]  now_ms,
    output dec_ctx_t                nxt
);

    logic [TIME_W-1:0] el;
    logic gt_debounce;
    logic gt_hold;
    logic gt_pulse;
    logic gt_wait;
    logic gt_half_max;
    logic gt_timeout;
    logic half_win;
    logic full_win;

    // Elapsed time wraps modulo 2^32.
    assign el          = now_ms - cur.stamp_ms;
    assign gt_debounce = el > TIME_W'(cfg.debounce_ms);
    assign gt_hold     = el > TIME_W'(cfg.max_hold_ms);
    assign gt_pulse    = el > TIME_W'(cfg.full_pulse_ms);
    assign gt_wait     = el > TIME_W'(cfg.second_press_wait_ms);
    assign gt_half_max = el > TIME_W'(cfg.half_max_ms);
    assign gt_timeout  = el > TIME_W'(FULL_WAIT_TIMEOUT_MS);
    assign half_win    = (el > TIME_W'(cfg.half_min_ms)) && (el < TIME_W'(cfg.half_max_ms));
    assign full_win    = (el > TIME_W'(cfg.full_min_ms)) && (el < TIME_W'(FULL_MAX_MS));

    always_comb
    begin
        nxt = cur;
        case (cfg.mode)
            MODE_ONE_PRESS:
            begin
                case (cur.state)
                    ST_RESET:
                    begin
                        nxt.shutter = SH_RELEASE;
                        nxt.state   = ST_IDLE;
                    end
                    ST_IDLE:
                    begin
                        nxt.shutter = SH_RELEASE;
                        if (power_on)
                        begin
                            nxt.state    = ST_CONNECT;
                            nxt.stamp_ms = now_ms;
                        end
                    end
                    ST_CONNECT:
                    begin
                        if (!power_on)
                        begin
                            nxt.state = ST_IDLE;
                        end
                        else if (gt_debounce)
                        begin
                            nxt.shutter  = SH_HALF;
                            nxt.state    = ST_ON;
                            nxt.stamp_ms = now_ms;
                        end
                    end
                    ST_ON:
                    begin
                        if (power_on)
                        begin
                            if (gt_hold)
                            begin
                                nxt.shutter = SH_RELEASE;
                            end
                        end
                        else if (gt_debounce)
                        begin
                            nxt.shutter  = SH_FULL;
                            nxt.state    = ST_DISCONNECT;
                            nxt.stamp_ms = now_ms;
                        end
                    end
                    ST_DISCONNECT:
                    begin
                        if (gt_pulse)
                        begin
                            nxt.shutter = SH_RELEASE;
                            nxt.state   = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        nxt.state = ST_RESET;
                    end
                endcase
            end
            MODE_TWO_PRESS:
            begin
                case (cur.state)
                    ST_RESET:
                    begin
                        nxt.shutter = SH_RELEASE;
                        nxt.state   = ST_IDLE;
                    end
                    ST_IDLE:
                    begin
                        if (power_on)
                        begin
                            nxt.state    = ST_CONNECT;
                            nxt.stamp_ms = now_ms;
                        end
                    end
                    ST_CONNECT:
                    begin
                        if (!power_on)
                        begin
                            nxt.state = ST_IDLE;
                        end
                        else if (gt_debounce)
                        begin
                            nxt.shutter  = SH_HALF;
                            nxt.state    = ST_ON;
                            nxt.stamp_ms = now_ms;
                        end
                    end
                    ST_ON:
                    begin
                        if (!power_on && gt_debounce)
                        begin
                            nxt.state    = ST_DISCONNECT;
                            nxt.stamp_ms = now_ms;
                        end
                    end
                    ST_DISCONNECT:
                    begin
                        if (power_on)
                        begin
                            if (gt_debounce)
                            begin
                                nxt.shutter  = SH_FULL;
                                nxt.state    = ST_FULL_ACTIVE;
                                nxt.stamp_ms = now_ms;
                            end
                        end
                        else if (gt_wait)
                        begin
                            nxt.shutter = SH_RELEASE;
                            nxt.state   = ST_IDLE;
                        end
                    end
                    ST_FULL_ACTIVE:
                    begin
                        if (!power_on)
                        begin
                            nxt.shutter = SH_RELEASE;
                            nxt.state   = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        nxt.state = ST_RESET;
                    end
                endcase
            end
            MODE_PULSE:
            begin
                case (cur.state)
                    ST_RESET:
                    begin
                        nxt.shutter = SH_RELEASE;
                        nxt.state   = ST_IDLE;
                    end
                    ST_IDLE:
                    begin
                        nxt.shutter = SH_RELEASE;
                        if (power_on)
                        begin
                            nxt.state    = ST_CONNECT;
                            nxt.stamp_ms = now_ms;
                        end
                    end
                    ST_CONNECT:
                    begin
                        if (!power_on)
                        begin
                            if (half_win)
                            begin
                                nxt.state    = ST_SHORT;
                                nxt.stamp_ms = now_ms;
                            end
                            else
                            begin
                                nxt.state = ST_IDLE;
                            end
                        end
                    end
                    ST_SHORT:
                    begin
                        if (power_on)
                        begin
                            nxt.state    = ST_CANCEL;
                            nxt.stamp_ms = now_ms;
                        end
                        else if (gt_half_max)
                        begin
                            nxt.shutter = SH_HALF;
                            nxt.state   = ST_HALF;
                        end
                    end
                    ST_CANCEL:
                    begin
                        if (!power_on)
                        begin
                            nxt.state = ST_IDLE;
                        end
                    end
                    ST_HALF:
                    begin
                        if (power_on)
                        begin
                            nxt.state    = ST_FULL;
                            nxt.stamp_ms = now_ms;
                        end
                        else if (gt_timeout)
                        begin
                            nxt.state = ST_IDLE;
                        end
                    end
                    ST_FULL:
                    begin
                        if (!power_on)
                        begin
                            if (full_win)
                            begin
                                nxt.shutter  = SH_FULL;
                                nxt.state    = ST_FULL_RESET;
                                nxt.stamp_ms = now_ms;
                            end
                            else if (half_win)
                            begin
                                nxt.state    = ST_SHORT;
                                nxt.stamp_ms = now_ms;
                            end
                            else
                            begin
                                nxt.state = ST_IDLE;
                            end
                        end
                    end
                    ST_FULL_RESET:
                    begin
                        if (gt_pulse)
                        begin
                            nxt.shutter = SH_RELEASE;
                            nxt.state   = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        nxt.state = ST_RESET;
                    end
                endcase
            end
            default:
            begin
                // No decoder runs: hold everything.
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/usbprs_checker.sv -----
// Port-level checker of the remote switch decoder and its bind to the top level.
`default_nettype none
`include "usb_power_remote_switch_decoder_top_defines.svh"

module usbprs_checker
    import usbprs_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] remote_state
);

    // A stalled result stays put.
    `USBPRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(remote_state))

    // Only release, half and full are ever reported.
    `USBPRS_ASSERT_SAME(a_state_code, clk, rst_n, out_valid, remote_state <= SH_FULL)

    // One sample fits behind a stalled result, then the input side must stall.
    `USBPRS_ASSERT_SAME(a_backpressure, clk, rst_n, $past(in_valid && !in_stall && out_valid && out_stall) && out_stall, in_stall)

    // A result appears only after an input transfer has passed through the input register.
    `USBPRS_ASSERT_SAME(a_no_invented, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind usb_power_remote_switch_decoder_top usbprs_checker u_usbprs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .remote_state (remote_state)
);

`default_nettype wire
